>>> hdl/bcgf_pkg.sv
`timescale 1ns / 1ps
// Package for the battery charge gauge filter: widths, tables, register map and shared types.
package bcgf_pkg;

    localparam int NOW_W   = 32;
    localparam int SUM_W   = 15;
    localparam int PCT_W   = 7;
    localparam int RATIO_W = 16;
    localparam int IVL_W   = 16;
    localparam int FILT_W  = 15;

    localparam int READINGS_PER_SAMPLE = 8;
    localparam int RATIO_FRAC_BITS     = 12;
    localparam int DEN_SHIFT           = $clog2(READINGS_PER_SAMPLE) + RATIO_FRAC_BITS;
    localparam int PCT_FRAC_BITS       = 8;
    localparam int FRAC_SHIFT          = DEN_SHIFT - PCT_FRAC_BITS;
    localparam int NUM_W               = SUM_W + RATIO_W;

    localparam int TABLE_POINTS = 7;
    localparam int PT_W         = $clog2(TABLE_POINTS);
    localparam int MV_W         = 13;

    localparam logic [MV_W-1:0] TBL_MV [TABLE_POINTS] =
        '{13'd3200, 13'd3500, 13'd3680, 13'd3780, 13'd3930, 13'd4050, 13'd4150};
    localparam logic [PCT_W-1:0] TBL_PCT [TABLE_POINTS] =
        '{7'd0, 7'd5, 7'd15, 7'd40, 7'd70, 7'd90, 7'd100};

    localparam logic [MV_W-1:0]   UV_LIMIT_MV  = 13'd2000;
    localparam logic [FILT_W-1:0] PCT_FULL_Q8  = 15'd25600;
    localparam logic [FILT_W:0]   ROUND_HALF   = 16'd128;

    // segment span widths: largest voltage step 300 mV, largest percent step 30
    localparam int DV_W      = 9;
    localparam int DP_W      = 5;
    localparam int DIFF_W    = 24;
    localparam int PROD_W    = DIFF_W + DP_W;
    localparam int DIV_NUM_W = 21;
    localparam int Q_W       = 15;
    localparam int REM_W     = DV_W + 1;
    localparam int DIV_CNT_W = $clog2(Q_W + 1);

    localparam int EMA_OLD  = 7;
    localparam int EMA_NEW  = 3;
    localparam int EMA_BIAS = 5;
    localparam int EMA_DIV  = 10;

    // ceil(2^21 / 10): exact division by EMA_DIV for numerators below 2^18
    localparam int EMA_NUM_W       = 18;
    localparam int EMA_RECIP_SHIFT = 21;
    localparam int EMA_PROD_W      = 36;
    localparam logic [EMA_NUM_W-1:0] EMA_RECIP = 18'd209716;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_DIVIDER_RATIO = 2'd0,
        REG_SAMPLE_INTERVAL = 2'd1,
        REG_LOW_THRESHOLD = 2'd2,
        REG_CRIT_THRESHOLD = 2'd3
    } t_reg_idx;

    localparam logic [RATIO_W-1:0] RST_DIVIDER_RATIO = 16'd8192;
    localparam logic [IVL_W-1:0]   RST_INTERVAL      = 16'd2000;
    localparam logic [PCT_W-1:0]   RST_LOW           = 7'd20;
    localparam logic [PCT_W-1:0]   RST_CRIT          = 7'd5;

    typedef struct packed {
        logic [RATIO_W-1:0] divider_ratio;
        logic [IVL_W-1:0]   sample_interval_ms;
        logic [PCT_W-1:0]   low_threshold_pct;
        logic [PCT_W-1:0]   critical_threshold_pct;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SEG,
        ST_PROD,
        ST_DIV_SEG,
        ST_EMA,
        ST_COMMIT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic seg;
        logic prod;
        logic seg_done;
        logic ema;
        logic commit;
        logic result;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic uv;
        logic in_range;
        logic div_busy;
        logic out_free;
    } t_sts;

    function automatic logic [NUM_W-1:0] mv_scaled(input logic [PT_W-1:0] idx);
        return NUM_W'(TBL_MV[idx]) << DEN_SHIFT;
    endfunction

endpackage

>>> hdl/bcgf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result transactions.
interface bcgf_in_if;
    import bcgf_pkg::*;
    logic                valid;
    logic                ready;
    logic [NOW_W-1:0]    now_ms;
    logic [SUM_W-1:0]    adc_sum_mv;

    modport source (output valid, output now_ms, output adc_sum_mv, input ready);
    modport sink   (input valid, input now_ms, input adc_sum_mv, output ready);
endinterface

interface bcgf_out_if;
    import bcgf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] charge_pct;
    logic             is_low;
    logic             is_critical;
    logic             sample_taken;
    logic             under_voltage;

    modport source (output valid, output charge_pct, output is_low, output is_critical,
                    output sample_taken, output under_voltage, input ready);
    modport sink   (input valid, input charge_pct, input is_low, input is_critical,
                    input sample_taken, input under_voltage, output ready);
endinterface

>>> hdl/bcgf_regs.sv
`timescale 1ns / 1ps
// APB configuration register bank.
module bcgf_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcgf_pkg::ADDR_W-1:0] paddr,
    input  logic [bcgf_pkg::DATA_W-1:0] pwdata,
    output logic [bcgf_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output bcgf_pkg::t_cfg              o_cfg
);
    import bcgf_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.divider_ratio          <= RST_DIVIDER_RATIO;
            r_cfg.sample_interval_ms     <= RST_INTERVAL;
            r_cfg.low_threshold_pct      <= RST_LOW;
            r_cfg.critical_threshold_pct <= RST_CRIT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DIVIDER_RATIO:   r_cfg.divider_ratio          <= pwdata[RATIO_W-1:0];
                REG_SAMPLE_INTERVAL: r_cfg.sample_interval_ms     <= pwdata[IVL_W-1:0];
                REG_LOW_THRESHOLD:   r_cfg.low_threshold_pct      <= pwdata[PCT_W-1:0];
                REG_CRIT_THRESHOLD:  r_cfg.critical_threshold_pct <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DIVIDER_RATIO:   prdata = DATA_W'(r_cfg.divider_ratio);
            REG_SAMPLE_INTERVAL: prdata = DATA_W'(r_cfg.sample_interval_ms);
            REG_LOW_THRESHOLD:   prdata = DATA_W'(r_cfg.low_threshold_pct);
            REG_CRIT_THRESHOLD:  prdata = DATA_W'(r_cfg.critical_threshold_pct);
            default:             prdata = '0;
        endcase
    end

endmodule

>>> hdl/bcgf_div.sv
`timescale 1ns / 1ps
// Restoring divider for table interpolation, one quotient bit per cycle.
module bcgf_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bcgf_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [bcgf_pkg::DV_W-1:0]      i_den,
    output logic                           o_busy,
    output logic [bcgf_pkg::Q_W-1:0]       o_quot
);
    import bcgf_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [REM_W-1:0]     r_rem;
    logic [Q_W-1:0]       r_nq;
    logic [DV_W-1:0]      r_den;
    logic [REM_W:0]       trial;
    logic                 q_bit;

    // upper numerator bits are always below the divisor, so the quotient fits Q_W bits
    assign trial  = {r_rem, r_nq[Q_W-1]};
    assign q_bit  = (trial >= (REM_W+1)'(r_den));
    assign o_busy = (r_cnt != '0);
    assign o_quot = r_nq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(Q_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= REM_W'(i_num[DIV_NUM_W-1:Q_W]);
            r_nq  <= i_num[Q_W-1:0];
            r_den <= i_den;
        end else if (o_busy) begin
            r_rem <= q_bit ? REM_W'(trial - (REM_W+1)'(r_den)) : trial[REM_W-1:0];
            r_nq  <= {r_nq[Q_W-2:0], q_bit};
        end
    end

endmodule

>>> hdl/bcgf_dp.sv
`timescale 1ns / 1ps
// Datapath: scaling multiply, table interpolation, EMA filter state and result register.
module bcgf_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bcgf_pkg::t_cfg             i_cfg,
    input  bcgf_pkg::t_cmd             i_cmd,
    output bcgf_pkg::t_sts             o_sts,
    input  logic [bcgf_pkg::NOW_W-1:0] i_now_ms,
    input  logic [bcgf_pkg::SUM_W-1:0] i_adc_sum_mv,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [bcgf_pkg::PCT_W-1:0] o_charge_pct,
    output logic                       o_is_low,
    output logic                       o_is_critical,
    output logic                       o_sample_taken,
    output logic                       o_under_voltage
);
    import bcgf_pkg::*;

    logic [NOW_W-1:0]     r_now;
    logic [SUM_W-1:0]     r_sum;
    logic [NUM_W-1:0]     r_num;
    logic                 r_skip;
    logic [DIFF_W-1:0]    r_diff;
    logic [DP_W-1:0]      r_dp;
    logic [DV_W-1:0]      r_dv;
    logic [FILT_W-1:0]    r_base;
    logic [FILT_W-1:0]    r_p;
    logic [EMA_NUM_W-1:0] r_ema;
    logic                 r_have;
    logic [NOW_W-1:0]     r_last;
    logic [FILT_W-1:0]    r_filt;
    logic                 r_out_valid;
    logic [PCT_W-1:0]     r_pct;
    logic                 r_low;
    logic                 r_crit;
    logic                 r_taken;
    logic                 r_uv;

    logic [NOW_W-1:0]      elapsed;
    logic                  uv;
    logic                  at_top;
    logic                  at_bottom;
    logic [PT_W-1:0]       seg_idx;
    logic [PT_W-1:0]       seg_hi;
    logic [NUM_W-1:0]      seg_lo_scaled;
    logic [PROD_W-1:0]     seg_prod;
    logic [EMA_NUM_W-1:0]  ema_num;
    logic [EMA_PROD_W-1:0] ema_prod;
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DV_W-1:0]       div_den;
    logic                  div_busy;
    logic [Q_W-1:0]        div_quot;
    logic [FILT_W:0]       interp;
    logic [FILT_W:0]       rounded;
    logic [PCT_W-1:0]      round_pct;
    logic [PCT_W-1:0]      res_pct;
    logic                  out_free;

    assign elapsed   = r_now - r_last;
    assign uv        = r_num < (NUM_W'(UV_LIMIT_MV) << DEN_SHIFT);
    assign at_top    = r_num >= mv_scaled(PT_W'(TABLE_POINTS - 1));
    assign at_bottom = r_num <= mv_scaled('0);

    always_comb begin
        seg_idx = '0;
        for (int i = 1; i < TABLE_POINTS - 1; i++) begin
            if (r_num >= mv_scaled(PT_W'(i))) begin
                seg_idx = PT_W'(i);
            end
        end
    end

    assign seg_hi        = seg_idx + 1'b1;
    assign seg_lo_scaled = mv_scaled(seg_idx);
    assign seg_prod      = PROD_W'(r_diff) * PROD_W'(r_dp);
    assign ema_num       = EMA_NUM_W'(EMA_OLD) * EMA_NUM_W'(r_filt)
                         + EMA_NUM_W'(EMA_NEW) * EMA_NUM_W'(r_p)
                         + EMA_NUM_W'(EMA_BIAS);
    assign ema_prod      = EMA_PROD_W'(r_ema) * EMA_PROD_W'(EMA_RECIP);

    assign div_start = i_cmd.prod;
    assign div_num   = seg_prod[FRAC_SHIFT +: DIV_NUM_W];
    assign div_den   = r_dv;

    bcgf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign interp    = {1'b0, r_base} + (FILT_W+1)'(div_quot);
    assign rounded   = {1'b0, r_filt} + ROUND_HALF;
    assign round_pct = rounded[PCT_FRAC_BITS +: PCT_W];
    assign res_pct   = (uv && !r_skip) ? '0 : round_pct;
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_now_ms;
            r_sum <= i_adc_sum_mv;
        end
        if (i_cmd.mul) begin
            r_num  <= NUM_W'(r_sum) * NUM_W'(i_cfg.divider_ratio);
            r_skip <= r_have && (elapsed < NOW_W'(i_cfg.sample_interval_ms));
        end
        if (i_cmd.seg) begin
            r_diff <= DIFF_W'(r_num - seg_lo_scaled);
            r_dv   <= DV_W'(TBL_MV[seg_hi] - TBL_MV[seg_idx]);
            r_dp   <= DP_W'(TBL_PCT[seg_hi] - TBL_PCT[seg_idx]);
            r_base <= FILT_W'(TBL_PCT[seg_idx]) << PCT_FRAC_BITS;
            r_p    <= at_top ? PCT_FULL_Q8 : '0;
        end else if (i_cmd.seg_done) begin
            r_p <= (interp > (FILT_W+1)'(PCT_FULL_Q8)) ? PCT_FULL_Q8 : interp[FILT_W-1:0];
        end
        if (i_cmd.ema) begin
            r_ema <= ema_num;
        end
        if (i_cmd.result) begin
            r_pct   <= res_pct;
            r_low   <= res_pct <= i_cfg.low_threshold_pct;
            r_crit  <= res_pct <= i_cfg.critical_threshold_pct;
            r_taken <= !r_skip;
            r_uv    <= uv && !r_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_last      <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_have <= 1'b1;
                r_last <= r_now;
                r_filt <= r_have ? ema_prod[EMA_RECIP_SHIFT +: FILT_W] : r_p;
            end
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.skip     = r_skip;
    assign o_sts.uv       = uv;
    assign o_sts.in_range = !at_top && !at_bottom;
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_free = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_charge_pct    = r_pct;
    assign o_is_low        = r_low;
    assign o_is_critical   = r_crit;
    assign o_sample_taken  = r_taken;
    assign o_under_voltage = r_uv;

endmodule

>>> hdl/bcgf_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing one request transaction through the datapath.
module bcgf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bcgf_pkg::t_sts i_sts,
    output bcgf_pkg::t_cmd o_cmd
);
    import bcgf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MUL;
            end
            ST_MUL: n_state = ST_SEG;
            ST_SEG: begin
                if (i_sts.skip || i_sts.uv) n_state = ST_RESULT;
                else if (!i_sts.in_range)   n_state = ST_EMA;
                else                        n_state = ST_PROD;
            end
            ST_PROD: n_state = ST_DIV_SEG;
            ST_DIV_SEG: begin
                if (!i_sts.div_busy) n_state = ST_EMA;
            end
            ST_EMA: n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_MUL:     o_cmd.mul      = 1'b1;
            ST_SEG:     o_cmd.seg      = 1'b1;
            ST_PROD:    o_cmd.prod     = 1'b1;
            ST_DIV_SEG: o_cmd.seg_done = !i_sts.div_busy;
            ST_EMA:     o_cmd.ema      = 1'b1;
            ST_COMMIT:  o_cmd.commit   = 1'b1;
            ST_RESULT:  o_cmd.result   = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> hdl/battery_charge_gauge_filter.sv
`timescale 1ns / 1ps
// Top level of the battery charge gauge filter.
// Each request transaction (timestamp, sum of eight ADC readings in mV) gives one result
// transaction. Requests inside the sample interval, and measurements below 2000 mV, go
// from the MUL and SEG states straight to RESULT, skipping interpolation and the EMA update.
// A measurement inside the table runs one 15-step restoring divider for the
// interpolation, and the 0.7/0.3 EMA update uses a reciprocal multiply; a reading off
// either end of the table skips the division. While the output register still holds an
// unaccepted result, the controller waits in RESULT before loading the next one, and the
// next request is accepted only after that. A finished result waits in the output
// register while the next request is accepted. The user must write registers over APB
// only while the block is idle; the block itself does not enforce this.
module battery_charge_gauge_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bcgf_in_if.sink                     i_in,
    bcgf_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bcgf_pkg::ADDR_W-1:0] paddr,
    input  logic [bcgf_pkg::DATA_W-1:0] pwdata,
    output logic [bcgf_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import bcgf_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    bcgf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bcgf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bcgf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_now_ms        (i_in.now_ms),
        .i_adc_sum_mv    (i_in.adc_sum_mv),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_charge_pct    (o_out.charge_pct),
        .o_is_low        (o_out.is_low),
        .o_is_critical   (o_out.is_critical),
        .o_sample_taken  (o_out.sample_taken),
        .o_under_voltage (o_out.under_voltage)
    );

endmodule

>>> test/tb_charge_gauge_monitor.sv
`timescale 1ns / 1ps
// Monitor for the charge gauge filter: tracks register writes, predicts each result and compares.
module charge_gauge_monitor
    import bcgf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bcgf_in_if                i_req,
    bcgf_out_if               i_res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [PCT_W-1:0] charge_pct;
        logic             is_low;
        logic             is_critical;
        logic             sample_taken;
        logic             under_voltage;
    } t_gauge_result;

    localparam longint unsigned SCALE_DEN = 64'(READINGS_PER_SAMPLE) << RATIO_FRAC_BITS;

    logic [RATIO_W-1:0] cfg_ratio;
    logic [IVL_W-1:0]   cfg_ivl;
    logic [PCT_W-1:0]   cfg_low;
    logic [PCT_W-1:0]   cfg_crit;

    logic               have_level;
    logic [NOW_W-1:0]   level_time_ms;
    logic [FILT_W-1:0]  level_q8;

    t_gauge_result      pending_charge_q [$];

    // num / SCALE_DEN is the battery voltage in mV
    function automatic logic [FILT_W-1:0] table_pct_q8(input longint unsigned num);
        longint unsigned lo, hi, dv, dp, q8;
        int k;
        if (num >= 64'(TBL_MV[TABLE_POINTS-1]) * SCALE_DEN)
            return FILT_W'(64'(TBL_PCT[TABLE_POINTS-1]) << PCT_FRAC_BITS);
        if (num <= 64'(TBL_MV[0]) * SCALE_DEN)
            return FILT_W'(64'(TBL_PCT[0]) << PCT_FRAC_BITS);
        for (k = 0; k < TABLE_POINTS - 1; k++) begin
            lo = 64'(TBL_MV[k]) * SCALE_DEN;
            hi = 64'(TBL_MV[k+1]) * SCALE_DEN;
            if (num >= lo && num < hi) begin
                dv = 64'(TBL_MV[k+1]) - 64'(TBL_MV[k]);
                dp = 64'(TBL_PCT[k+1]) - 64'(TBL_PCT[k]);
                q8 = (64'(TBL_PCT[k]) << PCT_FRAC_BITS)
                   + ((num - lo) * dp * 256) / (SCALE_DEN * dv);
                if (q8 > 64'(PCT_FULL_Q8))
                    q8 = 64'(PCT_FULL_Q8);
                return FILT_W'(q8);
            end
        end
        return '0;
    endfunction

    // Advances the filter state by one request and returns its result.
    function automatic t_gauge_result gauge_step(input logic [NOW_W-1:0] now,
                                                 input logic [SUM_W-1:0] adc_sum);
        t_gauge_result    res;
        longint unsigned  num;
        logic [NOW_W-1:0] since;
        logic [PCT_W-1:0] pct;
        logic [FILT_W-1:0] new_q8;
        int unsigned      ema;
        res   = '0;
        since = now - level_time_ms;
        if (have_level && since < NOW_W'(cfg_ivl)) begin
            pct = PCT_W'((int'(level_q8) + 128) >> PCT_FRAC_BITS);
        end else begin
            res.sample_taken = 1'b1;
            num = 64'(adc_sum) * 64'(cfg_ratio);
            if (num < 64'(UV_LIMIT_MV) * SCALE_DEN) begin
                res.under_voltage = 1'b1;
                pct = '0;
            end else begin
                new_q8 = table_pct_q8(num);
                if (!have_level) begin
                    level_q8 = new_q8;
                end else begin
                    ema = (EMA_OLD * int'(level_q8) + EMA_NEW * int'(new_q8) + EMA_BIAS) / EMA_DIV;
                    level_q8 = FILT_W'(ema);
                end
                have_level    = 1'b1;
                level_time_ms = now;
                pct = PCT_W'((int'(level_q8) + 128) >> PCT_FRAC_BITS);
            end
        end
        res.charge_pct  = pct;
        res.is_low      = (pct <= cfg_low);
        res.is_critical = (pct <= cfg_crit);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [PCT_W-1:0] want,
                               input logic [PCT_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_gauge_result want;
        t_gauge_result got;
        if (!i_rst_n) begin
            cfg_ratio     = RST_DIVIDER_RATIO;
            cfg_ivl       = RST_INTERVAL;
            cfg_low       = RST_LOW;
            cfg_crit      = RST_CRIT;
            have_level    = 1'b0;
            level_time_ms = '0;
            level_q8      = '0;
            o_fail_count  = 0;
            pending_charge_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_DIVIDER_RATIO:   cfg_ratio = i_pwdata[RATIO_W-1:0];
                    REG_SAMPLE_INTERVAL: cfg_ivl   = i_pwdata[IVL_W-1:0];
                    REG_LOW_THRESHOLD:   cfg_low   = i_pwdata[PCT_W-1:0];
                    REG_CRIT_THRESHOLD:  cfg_crit  = i_pwdata[PCT_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                got = {i_res.charge_pct, i_res.is_low, i_res.is_critical,
                       i_res.sample_taken, i_res.under_voltage};
                if (pending_charge_q.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_charge_q.pop_front();
                    check_field("charge_pct", want.charge_pct, got.charge_pct);
                    check_field("is_low", PCT_W'(want.is_low), PCT_W'(got.is_low));
                    check_field("is_critical", PCT_W'(want.is_critical), PCT_W'(got.is_critical));
                    check_field("sample_taken", PCT_W'(want.sample_taken),
                                PCT_W'(got.sample_taken));
                    check_field("under_voltage", PCT_W'(want.under_voltage),
                                PCT_W'(got.under_voltage));
                end
            end
            if (i_req.valid && i_req.ready)
                pending_charge_q.push_back(gauge_step(i_req.now_ms, i_req.adc_sum_mv));
        end
        o_pending = pending_charge_q.size();
    end

endmodule

>>> test/tb_battery_charge_gauge_filter.sv
`timescale 1ns / 1ps
// Testbench top for the charge gauge filter: clock, reset, stimulus, register writes and verdict.
module tb_battery_charge_gauge_filter;
    import bcgf_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 156;

    localparam logic [SUM_W-1:0] SWEEP_SUMS [15] = '{
        15'd7999, 15'd8000, 15'd12799, 15'd12800, 15'd12801, 15'd14000, 15'd14720,
        15'd15120, 15'd15720, 15'd16200, 15'd16599, 15'd16600, 15'd16601, 15'd32767, 15'd0
    };

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int gap_pct = 0;
    bit calm    = 1'b0;
    int stall_cycles = 0;

    bcgf_in_if  req_if ();
    bcgf_out_if res_if ();

    battery_charge_gauge_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    charge_gauge_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #HALF_PERIOD_NS i_clk = ~i_clk;

    // leaves psel high so back-to-back writes go straight to the next setup phase
    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [RATIO_W-1:0] ratio, input logic [IVL_W-1:0] ivl,
                                input logic [PCT_W-1:0] low, input logic [PCT_W-1:0] crit);
        apb_write(REG_DIVIDER_RATIO, DATA_W'(ratio));
        apb_write(REG_SAMPLE_INTERVAL, DATA_W'(ivl));
        apb_write(REG_LOW_THRESHOLD, DATA_W'(low));
        apb_write(REG_CRIT_THRESHOLD, DATA_W'(crit));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_reading(input logic [NOW_W-1:0] now, input logic [SUM_W-1:0] adc_sum);
        req_if.valid      <= 1'b1;
        req_if.now_ms     <= now;
        req_if.adc_sum_mv <= adc_sum;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        req_if.valid      <= 1'b0;
        req_if.now_ms     <= '0;
        req_if.adc_sum_mv <= '0;
        res_if.ready      <= 1'b0;
    end

    // result side back-pressure
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (calm) begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(40, 120)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
                || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [NOW_W-1:0]   clock_ms;
        logic [SUM_W-1:0]   adc_sum;
        logic [RATIO_W-1:0] ratio;
        logic [IVL_W-1:0]   ivl;
        logic [PCT_W-1:0]   low;
        logic [PCT_W-1:0]   crit;
        longint unsigned    span;
        longint unsigned    scaled;
        int                 ph;
        int                 n;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: first sample under voltage, seeding, rate limit across the wrap
        send_reading(32'd0, 15'd0);
        send_reading(32'hFFFF_FFFF, 15'd32767);
        send_reading(32'd999, 15'd0);
        send_reading(32'd1998, 15'd12800);
        send_reading(32'd1999, 15'd12800);
        send_reading(32'd3998, 15'd7999);
        send_reading(32'd3999, 15'd7999);
        send_reading(32'd4000, 15'd16600);
        drain();

        // measure on every request, sweep the table corners
        write_config(16'd8192, 16'd0, 7'd100, 7'd0);
        for (n = 0; n < 15; n++)
            send_reading($urandom(), SWEEP_SUMS[n]);
        drain();

        // zero divider ratio, thresholds above full scale
        write_config(16'd0, 16'd0, 7'd127, 7'd127);
        send_reading($urandom(), 15'd32767);
        send_reading($urandom(), 15'd20000);
        drain();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ratio = 16'd1;
                1: ratio = 16'd65535;
                default: begin
                    case ($urandom_range(0, 3))
                        0, 1: ratio = 16'd8192;
                        2: ratio = RATIO_W'($urandom_range(4096, 16384));
                        default: ratio = RATIO_W'($urandom_range(1, 65535));
                    endcase
                end
            endcase
            if (ph == 2)
                ivl = 16'd65535;
            else if (ph == 3 || ph == 7)
                ivl = 16'd0;
            else
                ivl = ($urandom_range(0, 1) == 0) ? 16'd2000 : IVL_W'($urandom_range(1, 5000));
            if (ph == 4) begin
                low  = 7'd0;
                crit = 7'd0;
            end else if (ph == 5) begin
                low  = 7'd127;
                crit = 7'd127;
            end else begin
                low  = ($urandom_range(0, 3) == 0) ? PCT_W'($urandom_range(0, 127))
                                                   : PCT_W'($urandom_range(5, 60));
                crit = (ph == 6) ? 7'd100 : PCT_W'($urandom_range(0, 30));
            end
            write_config(ratio, ivl, low, crit);

            gap_pct  = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
            calm     = (ph == NUM_PHASES - 1);
            clock_ms = $urandom();

            for (n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: span = (ivl == 0) ? 0 : $urandom_range(0, int'(ivl) - 1);
                    4, 5, 6, 7: span = 64'(ivl) + $urandom_range(0, 3000);
                    8: span = (ivl == 0) ? 0 : 64'(ivl) - $urandom_range(0, 1);
                    default: span = $urandom();
                endcase
                clock_ms = clock_ms + NOW_W'(span);
                if ($urandom_range(0, 4) == 0) begin
                    adc_sum = SUM_W'($urandom_range(0, 32767));
                end else begin
                    scaled = (64'($urandom_range(1900, 4300)) * 64'(32768)) / 64'(ratio)
                           + $urandom_range(0, 7);
                    adc_sum = (scaled > 64'd32767) ? 15'd32767 : SUM_W'(scaled);
                end
                send_reading(clock_ms, adc_sum);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
